FILE: hw/rtl/al_pkg.sv
`default_nettype none

package al_pkg;

  localparam int WORD_W = 32;
  localparam int CAP_W  = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_GET    = 2'd2,
    REQ_SEARCH = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_INVALID   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/al_req_if.sv
`default_nettype none

interface al_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [4:0]  position;
  logic [31:0] value;

  modport source (output valid, req_type, position, value, input ready);
  modport sink   (input valid, req_type, position, value, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/al_rsp_if.sv
`default_nettype none

interface al_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] data_out;
  logic [3:0]  found_index;
  logic [4:0]  count;
  logic        is_empty;
  logic        is_full;

  modport source (output valid, status, data_out, found_index, count, is_empty, is_full,
                  input ready);
  modport sink   (input valid, status, data_out, found_index, count, is_empty, is_full,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/al_cell.sv
`default_nettype none

module al_cell #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  wire                          clk,
  input  wire  al_pkg::cmd_t           cmd,
  input  wire  [CW-1:0]                pos,
  input  wire  [CW-1:0]                cnt,
  input  wire  [al_pkg::WORD_W-1:0]    key,
  input  wire  [al_pkg::WORD_W-1:0]    left_d,
  input  wire  [al_pkg::WORD_W-1:0]    right_d,
  output logic [al_pkg::WORD_W-1:0]    q,
  output logic                         hit
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  always_ff @(posedge clk) begin
    if (cmd.ins && (MY_IDX == pos)) begin
      q <= key;
    end else if (cmd.ins && (MY_IDX > pos)) begin
      q <= left_d;
    end else if (cmd.rem && (MY_IDX >= pos)) begin
      q <= right_d;
    end
  end

  assign hit = (MY_IDX < cnt) && (q == key);

endmodule

`default_nettype wire

FILE: hw/rtl/array_list_engine.sv
// Channel  Dir  Beat
// req      in   req_type, position, value
// rsp      out  status, data_out, found_index, count, is_empty, is_full
// cfg      in   cfg_we, cfg_wdata (capacity)
//
// One request per cycle while rsp is not stalled; the result is registered and appears the cycle after acceptance.
// Each cell shifts with its neighbour in the accepting cycle; search compares all cells at once.
// Reset clears the count, the result valid and sets capacity to 16; entries are not cleared.
// req is held off only while a result waits on a stalled rsp.
`default_nettype none

module array_list_engine #(
  parameter int DEPTH = 16
) (
  input  wire                        clk,
  input  wire                        rst,
  al_req_if.sink                     req,
  al_rsp_if.source                   rsp,
  input  wire                        cfg_we,
  input  wire  [al_pkg::CAP_W-1:0]   cfg_wdata
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = (CW > 5) ? CW : 5;

  logic [al_pkg::CAP_W-1:0]   capacity;
  logic [CW-1:0]              count;
  logic [CW-1:0]              count_next;
  logic                       accept;
  al_pkg::cmd_t               cmd;
  al_pkg::status_t            status_next;
  logic [al_pkg::WORD_W-1:0]  data_next;
  logic [IW-1:0]              found;
  logic                       any_hit;
  logic [PW-1:0]              pos_w;
  logic [PW-1:0]              cnt_w;
  logic [PW-1:0]              cap_w;
  logic [PW-1:0]              eff_cap;
  logic [CW-1:0]              pos_c;
  logic [al_pkg::WORD_W-1:0]  q [DEPTH];
  logic [DEPTH-1:0]           hit;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign pos_w = PW'(req.position);
  assign cnt_w = PW'(count);
  assign cap_w = PW'(capacity);
  assign pos_c = CW'(req.position);

  always_comb begin
    if (cap_w == '0) begin
      eff_cap = PW'(1);
    end else if (cap_w > PW'(DEPTH)) begin
      eff_cap = PW'(DEPTH);
    end else begin
      eff_cap = cap_w;
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [al_pkg::WORD_W-1:0] left_d;
      logic [al_pkg::WORD_W-1:0] right_d;
      if (g == 0) begin : g_first
        assign left_d = '0;
      end else begin : g_mid_l
        assign left_d = q[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign right_d = '0;
      end else begin : g_mid_r
        assign right_d = q[g+1];
      end
      al_cell #(
        .CW  (CW),
        .IDX (g)
      ) u_cell (
        .clk     (clk),
        .cmd     (cmd),
        .pos     (pos_c),
        .cnt     (count),
        .key     (req.value),
        .left_d  (left_d),
        .right_d (right_d),
        .q       (q[g]),
        .hit     (hit[g])
      );
    end
  endgenerate

  always_comb begin
    found   = '0;
    any_hit = |hit;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found = IW'(i);
      end
    end
  end

  always_comb begin
    cmd         = '0;
    status_next = al_pkg::ST_OK;
    data_next   = '0;
    count_next  = count;
    case (al_pkg::req_t'(req.req_type))
      al_pkg::REQ_INSERT: begin
        if (cnt_w >= eff_cap) begin
          status_next = al_pkg::ST_OVERFLOW;
        end else if (pos_w > cnt_w) begin
          status_next = al_pkg::ST_INVALID;
        end else begin
          cmd.ins    = accept;
          count_next = count + 1'b1;
        end
      end
      al_pkg::REQ_REMOVE: begin
        if (count == '0) begin
          status_next = al_pkg::ST_UNDERFLOW;
        end else if (pos_w >= cnt_w) begin
          status_next = al_pkg::ST_INVALID;
        end else begin
          cmd.rem    = accept;
          data_next  = q[pos_c[IW-1:0]];
          count_next = count - 1'b1;
        end
      end
      al_pkg::REQ_GET: begin
        if (pos_w >= cnt_w) begin
          status_next = al_pkg::ST_INVALID;
        end else begin
          data_next = q[pos_c[IW-1:0]];
        end
      end
      default: begin
        if (!any_hit) begin
          status_next = al_pkg::ST_NOT_FOUND;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= al_pkg::CAP_RESET;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (accept) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status      <= status_next;
      rsp.data_out    <= data_next;
      rsp.found_index <= (al_pkg::req_t'(req.req_type) == al_pkg::REQ_SEARCH && any_hit)
                         ? 4'(found) : 4'd0;
      rsp.count       <= 5'(count_next);
      rsp.is_empty    <= (count_next == '0);
      rsp.is_full     <= (PW'(count_next) >= eff_cap);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    PW'(count) <= PW'(DEPTH))
    else $error("entry count above depth");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(count))
    else $error("entry count moved without a request beat");

  a_underflow: assert property (@(posedge clk) disable iff (rst)
    accept && req.req_type == al_pkg::REQ_REMOVE && count == '0
    |=> rsp.status == al_pkg::ST_UNDERFLOW && rsp.count == 5'd0)
    else $error("remove on empty list did not report underflow");
`endif

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 12;
  localparam int LIST_DEPTH   = 16;
  localparam int IDLE_LIMIT   = 2000;
  localparam int MAX_REPORTS  = 10;
  localparam int NUM_DIRECTED = 24;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 200;
  localparam int TAIL_CYCLES  = 4;

  typedef struct packed {
    al_pkg::req_t op;
    logic [4:0]   pos;
    logic [31:0]  val;
  } list_req_t;

  typedef struct packed {
    al_pkg::status_t status;
    logic [31:0]     data_out;
    logic [3:0]      found_index;
    logic [4:0]      count;
    logic            is_empty;
    logic            is_full;
  } list_rsp_t;

  typedef struct packed {
    logic [al_pkg::CAP_W-1:0] cap;
    list_req_t                req;
    logic                     typed;
    list_rsp_t                rsp;
  } directed_row_t;

  localparam list_rsp_t NO_RSP = '0;

  localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
    '{5'd16, '{al_pkg::REQ_REMOVE, 5'd31, 32'h0000_0000}, 1'b1,
      '{al_pkg::ST_UNDERFLOW, 32'h0, 4'd0, 5'd0, 1'b1, 1'b0}},
    '{5'd16, '{al_pkg::REQ_GET,    5'd0,  32'h0000_0000}, 1'b1,
      '{al_pkg::ST_INVALID,   32'h0, 4'd0, 5'd0, 1'b1, 1'b0}},
    '{5'd16, '{al_pkg::REQ_SEARCH, 5'd31, 32'h0000_0000}, 1'b1,
      '{al_pkg::ST_NOT_FOUND, 32'h0, 4'd0, 5'd0, 1'b1, 1'b0}},
    '{5'd16, '{al_pkg::REQ_INSERT, 5'd1,  32'h0000_0005}, 1'b1,
      '{al_pkg::ST_INVALID,   32'h0, 4'd0, 5'd0, 1'b1, 1'b0}},
    '{5'd16, '{al_pkg::REQ_INSERT, 5'd0,  32'hFFFF_FFFF}, 1'b1,
      '{al_pkg::ST_OK,        32'h0, 4'd0, 5'd1, 1'b0, 1'b0}},
    '{5'd16, '{al_pkg::REQ_INSERT, 5'd0,  32'h0000_0000}, 1'b1,
      '{al_pkg::ST_OK,        32'h0, 4'd0, 5'd2, 1'b0, 1'b0}},
    '{5'd16, '{al_pkg::REQ_INSERT, 5'd2,  32'h8000_0000}, 1'b0, NO_RSP},
    '{5'd16, '{al_pkg::REQ_INSERT, 5'd1,  32'hFFFF_FFFF}, 1'b0, NO_RSP},
    '{5'd16, '{al_pkg::REQ_SEARCH, 5'd0,  32'hFFFF_FFFF}, 1'b0, NO_RSP},
    '{5'd16, '{al_pkg::REQ_SEARCH, 5'd0,  32'h1234_5678}, 1'b1,
      '{al_pkg::ST_NOT_FOUND, 32'h0, 4'd0, 5'd4, 1'b0, 1'b0}},
    '{5'd16, '{al_pkg::REQ_GET,    5'd4,  32'h0000_0000}, 1'b1,
      '{al_pkg::ST_INVALID,   32'h0, 4'd0, 5'd4, 1'b0, 1'b0}},
    '{5'd16, '{al_pkg::REQ_REMOVE, 5'd31, 32'h0000_0000}, 1'b1,
      '{al_pkg::ST_INVALID,   32'h0, 4'd0, 5'd4, 1'b0, 1'b0}},
    '{5'd16, '{al_pkg::REQ_INSERT, 5'd31, 32'h0000_0001}, 1'b1,
      '{al_pkg::ST_INVALID,   32'h0, 4'd0, 5'd4, 1'b0, 1'b0}},
    '{5'd16, '{al_pkg::REQ_GET,    5'd3,  32'h0000_0000}, 1'b0, NO_RSP},
    '{5'd2,  '{al_pkg::REQ_INSERT, 5'd31, 32'h0000_0007}, 1'b1,
      '{al_pkg::ST_OVERFLOW,  32'h0, 4'd0, 5'd4, 1'b0, 1'b1}},
    '{5'd2,  '{al_pkg::REQ_REMOVE, 5'd1,  32'h0000_0000}, 1'b0, NO_RSP},
    '{5'd2,  '{al_pkg::REQ_REMOVE, 5'd0,  32'h0000_0000}, 1'b0, NO_RSP},
    '{5'd2,  '{al_pkg::REQ_REMOVE, 5'd1,  32'h0000_0000}, 1'b0, NO_RSP},
    '{5'd0,  '{al_pkg::REQ_INSERT, 5'd1,  32'h5A5A_5A5A}, 1'b1,
      '{al_pkg::ST_OVERFLOW,  32'h0, 4'd0, 5'd1, 1'b0, 1'b1}},
    '{5'd0,  '{al_pkg::REQ_REMOVE, 5'd0,  32'h0000_0000}, 1'b0, NO_RSP},
    '{5'd0,  '{al_pkg::REQ_INSERT, 5'd0,  32'hA5A5_A5A5}, 1'b0, NO_RSP},
    '{5'd31, '{al_pkg::REQ_INSERT, 5'd1,  32'h0F0F_0F0F}, 1'b0, NO_RSP},
    '{5'd31, '{al_pkg::REQ_SEARCH, 5'd16, 32'h0F0F_0F0F}, 1'b0, NO_RSP},
    '{5'd31, '{al_pkg::REQ_REMOVE, 5'd1,  32'h0000_0000}, 1'b0, NO_RSP}
  };

  localparam logic [al_pkg::CAP_W-1:0] PHASE_CAPS [NUM_PHASES] = '{
    5'd16, 5'd1, 5'd0, 5'd31, 5'd6, 5'd16, 5'd3, 5'd12
  };

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_we;
  logic [al_pkg::CAP_W-1:0] cfg_wdata;

  logic [31:0]              list_words [LIST_DEPTH];
  int                       list_count;
  logic [al_pkg::CAP_W-1:0] list_cap;
  list_rsp_t                pending_rsp [$];
  int                       error_count = 0;
  int                       idle_cycles = 0;
  int                       burst_left  = 0;

  al_req_if req_ch ();
  al_rsp_if rsp_ch ();

  array_list_engine #(
    .DEPTH(LIST_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int effective_capacity();
    if (list_cap == 0) return 1;
    if (list_cap > LIST_DEPTH) return LIST_DEPTH;
    return int'(list_cap);
  endfunction

  function automatic list_rsp_t apply_list_request(list_req_t r);
    list_rsp_t o;
    int        lim;
    int        i;
    o = '0;
    o.status = al_pkg::ST_OK;
    lim = effective_capacity();
    case (r.op)
      al_pkg::REQ_INSERT: begin
        if (list_count >= lim) o.status = al_pkg::ST_OVERFLOW;
        else if (int'(r.pos) > list_count) o.status = al_pkg::ST_INVALID;
        else begin
          for (i = list_count; i > int'(r.pos); i--) list_words[i] = list_words[i-1];
          list_words[r.pos] = r.val;
          list_count++;
        end
      end
      al_pkg::REQ_REMOVE: begin
        if (list_count == 0) o.status = al_pkg::ST_UNDERFLOW;
        else if (int'(r.pos) >= list_count) o.status = al_pkg::ST_INVALID;
        else begin
          o.data_out = list_words[r.pos];
          for (i = int'(r.pos); i + 1 < list_count; i++) list_words[i] = list_words[i+1];
          list_count--;
        end
      end
      al_pkg::REQ_GET: begin
        if (int'(r.pos) >= list_count) o.status = al_pkg::ST_INVALID;
        else o.data_out = list_words[r.pos];
      end
      default: begin
        o.status = al_pkg::ST_NOT_FOUND;
        for (i = list_count - 1; i >= 0; i--) begin
          if (list_words[i] == r.val) begin
            o.status = al_pkg::ST_OK;
            o.found_index = 4'(i);
          end
        end
      end
    endcase
    o.count    = 5'(list_count);
    o.is_empty = (list_count == 0);
    o.is_full  = (list_count >= lim);
    return o;
  endfunction

  function automatic list_req_t random_request(logic filling);
    list_req_t r;
    int        roll;
    int        ins_cut;
    int        rem_cut;
    roll    = $urandom_range(0, 99);
    ins_cut = filling ? 55 : 20;
    rem_cut = filling ? 75 : 70;
    if (roll < ins_cut) r.op = al_pkg::REQ_INSERT;
    else if (roll < rem_cut) r.op = al_pkg::REQ_REMOVE;
    else if (roll < 88) r.op = al_pkg::REQ_GET;
    else r.op = al_pkg::REQ_SEARCH;

    if ($urandom_range(0, 3) == 0) r.val = 32'($urandom_range(0, 3));
    else r.val = $urandom();
    if (r.op == al_pkg::REQ_SEARCH && list_count > 0 && $urandom_range(0, 2) != 0)
      r.val = list_words[$urandom_range(0, list_count - 1)];

    if ($urandom_range(0, 9) == 0 || r.op == al_pkg::REQ_SEARCH)
      r.pos = 5'($urandom_range(0, 31));
    else if (r.op == al_pkg::REQ_INSERT) r.pos = 5'($urandom_range(0, list_count));
    else if (list_count > 0) r.pos = 5'($urandom_range(0, list_count - 1));
    else r.pos = 5'd0;
    return r;
  endfunction

  // Hold valid low before calling; waits for a falling clock edge before each check that no result is pending.
  task automatic wait_drained();
    do @(negedge clk); while (pending_rsp.size() != 0);
  endtask

  task automatic write_capacity(input logic [al_pkg::CAP_W-1:0] cap);
    req_ch.valid <= 1'b0;
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we   <= 1'b0;
    list_cap = cap;
  endtask

  task automatic drive_request(input list_req_t r, input logic typed, input list_rsp_t typed_rsp);
    list_rsp_t predicted;
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= r.op;
    req_ch.position <= r.pos;
    req_ch.value    <= r.val;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    predicted = apply_list_request(r);
    pending_rsp.push_back(typed ? typed_rsp : predicted);
    @(negedge clk);
  endtask

  task automatic pace_sender(input logic steady);
    if (steady) return;
    if (burst_left > 0) burst_left--;
    else begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  initial begin
    logic [15:0] stall_pattern;
    int          pattern_age;
    rsp_ch.ready  = 1'b0;
    stall_pattern = 16'hFFFF;
    pattern_age   = 0;
    forever begin
      @(negedge clk);
      if (pattern_age == 0) begin
        case ($urandom_range(0, 4))
          0: stall_pattern = 16'hFFFF;
          1: stall_pattern = 16'hAAAA;
          2: stall_pattern = 16'h8001;
          3: stall_pattern = 16'hF0F0;
          default: stall_pattern = 16'($urandom()) | 16'h0001;
        endcase
        pattern_age = $urandom_range(50, 300);
      end
      pattern_age--;
      rsp_ch.ready <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    end
  end

  always @(posedge clk) begin
    list_rsp_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_rsp.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected result beat: status %0d data %h index %0d count %0d",
                   rsp_ch.status, rsp_ch.data_out, rsp_ch.found_index, rsp_ch.count);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_ch.status !== want.status || rsp_ch.data_out !== want.data_out ||
            rsp_ch.found_index !== want.found_index || rsp_ch.count !== want.count ||
            rsp_ch.is_empty !== want.is_empty || rsp_ch.is_full !== want.is_full) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("mismatch at %0t: expected st %0d data %h idx %0d cnt %0d e %0b f %0b",
                     $realtime, want.status, want.data_out, want.found_index, want.count,
                     want.is_empty, want.is_full,
                     "; got st %0d data %h idx %0d cnt %0d e %0b f %0b",
                     rsp_ch.status, rsp_ch.data_out, rsp_ch.found_index, rsp_ch.count,
                     rsp_ch.is_empty, rsp_ch.is_full);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int                       k;
    int                       p;
    int                       n;
    logic                     filling;
    logic [al_pkg::CAP_W-1:0] cap;
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.req_type = al_pkg::REQ_INSERT;
    req_ch.position = '0;
    req_ch.value    = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = al_pkg::CAP_RESET;
    list_count      = 0;
    list_cap        = al_pkg::CAP_RESET;
    filling         = 1'b1;
    for (k = 0; k < LIST_DEPTH; k++) list_words[k] = '0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    for (k = 0; k < NUM_DIRECTED; k++) begin
      if (DIRECTED[k].cap != list_cap) write_capacity(DIRECTED[k].cap);
      drive_request(DIRECTED[k].req, DIRECTED[k].typed, DIRECTED[k].rsp);
      pace_sender(1'b0);
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      cap = (p < NUM_PHASES - 2) ? PHASE_CAPS[p] : al_pkg::CAP_W'($urandom_range(0, 31));
      write_capacity(cap);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 32 == 0) filling = $urandom_range(0, 1);
        drive_request(random_request(filling), 1'b0, NO_RSP);
        if ($urandom_range(0, 149) == 0) begin
          req_ch.valid <= 1'b0;
          wait_drained();
        end else
          pace_sender(p == 2);
      end
    end

    req_ch.valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
hw/rtl/al_pkg.sv
hw/rtl/al_req_if.sv
hw/rtl/al_rsp_if.sv
hw/rtl/al_cell.sv
hw/rtl/array_list_engine.sv
tb/testbench.sv
